FILE: hw/rtl/psf_pkg.sv
// Shared types, constants and the character classifier of the printable string finder.
package psf_pkg;

	localparam int PSF_OFFSET_BITS = 48;
	localparam int PSF_COUNT_BITS = 32;

	localparam int CFG_INDEX_BITS = 2;
	localparam int CFG_DATA_BITS = 16;
	localparam int MIN_LENGTH_BITS = 16;

	localparam logic [CFG_INDEX_BITS-1:0] REG_MIN_LENGTH = 2'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_ESCAPE_MODE = 2'd1;
	localparam logic [CFG_INDEX_BITS-1:0] REG_WIDE_MODE = 2'd2;

	localparam logic [MIN_LENGTH_BITS-1:0] DEF_MIN_LENGTH = 16'd4;

	localparam logic [7:0] CHR_NUL = 8'h00;
	localparam logic [7:0] CHR_BEL = 8'h07;
	localparam logic [7:0] CHR_CR = 8'h0D;
	localparam logic [7:0] CHR_SPACE = 8'h20;
	localparam logic [7:0] CHR_TILDE = 8'h7E;

	typedef struct packed {
		logic [MIN_LENGTH_BITS-1:0] min_length;
		logic                       escape_mode;
		logic                       wide_mode;
	} cfg_t;

	// Printable ASCII, plus bell, backspace and the whitespace controls in escape mode.
	function automatic logic is_string_char(input logic [7:0] b, input logic escape_mode);
		logic printable;
		logic control;
		printable = (b >= CHR_SPACE) && (b <= CHR_TILDE);
		control = escape_mode && (b >= CHR_BEL) && (b <= CHR_CR);
		return printable || control;
	endfunction

endpackage

FILE: hw/rtl/psf_cfg.sv
// Configuration registers of the printable string finder.
module psf_cfg (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_write,
	input  logic [psf_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
	input  logic [psf_pkg::CFG_DATA_BITS-1:0]    cfg_data,
	output psf_pkg::cfg_t                        cfg
);
	import psf_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.min_length <= DEF_MIN_LENGTH;
			cfg_q.escape_mode <= 1'b0;
			cfg_q.wide_mode <= 1'b0;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_MIN_LENGTH: cfg_q.min_length <= cfg_data[MIN_LENGTH_BITS-1:0];
				REG_ESCAPE_MODE: cfg_q.escape_mode <= cfg_data[0];
				REG_WIDE_MODE: cfg_q.wide_mode <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

FILE: hw/rtl/psf_scan.sv
// Run tracking state, report decision and result register of the printable string finder.
module psf_scan #(
	parameter int OFFSET_BITS = psf_pkg::PSF_OFFSET_BITS,
	parameter int COUNT_BITS = psf_pkg::PSF_COUNT_BITS
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  psf_pkg::cfg_t          cfg,
	input  logic                   valid_s1,
	input  logic [7:0]             data_byte_s1,
	input  logic                   end_of_file_s1,
	output logic                   fire,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [OFFSET_BITS-1:0] start_offset,
	output logic [COUNT_BITS-1:0]  run_length
);
	import psf_pkg::*;

	localparam int CMP_W = (COUNT_BITS > MIN_LENGTH_BITS) ? COUNT_BITS : MIN_LENGTH_BITS;

	logic [COUNT_BITS-1:0]  run_count_q;
	logic                   zero_byte_due_q;
	logic [OFFSET_BITS-1:0] byte_position_q;
	logic [OFFSET_BITS-1:0] run_start_q;

	logic [COUNT_BITS-1:0]  run_count_n;
	logic                   zero_byte_due_n;
	logic [OFFSET_BITS-1:0] run_start_n;

	logic                   out_valid_q;
	logic [OFFSET_BITS-1:0] start_offset_q;
	logic [COUNT_BITS-1:0]  run_length_q;

	logic [MIN_LENGTH_BITS-1:0] need;
	logic                       is_char;
	logic                       rep_pre;
	logic                       rep_post;
	logic                       emit_pre;
	logic                       emit_post;
	logic                       emit;

	assign fire = valid_s1 && (!out_valid_q || !out_stall);
	assign need = (cfg.min_length == '0) ? MIN_LENGTH_BITS'(1) : cfg.min_length;
	assign is_char = is_string_char(data_byte_s1, cfg.escape_mode);

	always_comb begin
		run_count_n = run_count_q;
		zero_byte_due_n = zero_byte_due_q;
		run_start_n = run_start_q;
		if (!is_char) begin
			// A zero byte that pays off a pending wide-mode zero keeps the run open.
			if (data_byte_s1 != CHR_NUL || !zero_byte_due_q) begin
				run_count_n = '0;
			end else begin
				zero_byte_due_n = 1'b0;
			end
		end else if (zero_byte_due_q) begin
			run_count_n = '0;
		end else begin
			zero_byte_due_n = cfg.wide_mode;
			if (run_count_q == '0) begin
				run_start_n = byte_position_q;
			end
			if (run_count_q != '1) begin
				run_count_n = run_count_q + COUNT_BITS'(1);
			end
		end
	end

	assign rep_pre = !zero_byte_due_q && (run_count_q != '0)
		&& (CMP_W'(run_count_q) >= CMP_W'(need));
	assign rep_post = !zero_byte_due_n && (run_count_n != '0)
		&& (CMP_W'(run_count_n) >= CMP_W'(need));
	assign emit_pre = !is_char && rep_pre;
	assign emit_post = end_of_file_s1 && !emit_pre && rep_post;
	assign emit = emit_pre || emit_post;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_count_q <= '0;
			zero_byte_due_q <= 1'b0;
			byte_position_q <= '0;
			run_start_q <= '0;
		end else if (fire) begin
			run_start_q <= run_start_n;
			if (end_of_file_s1) begin
				run_count_q <= '0;
				zero_byte_due_q <= 1'b0;
				byte_position_q <= '0;
			end else begin
				run_count_q <= run_count_n;
				zero_byte_due_q <= zero_byte_due_n;
				byte_position_q <= byte_position_q + OFFSET_BITS'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || !out_stall) begin
			out_valid_q <= fire && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && emit) begin
			start_offset_q <= emit_pre ? run_start_q : run_start_n;
			run_length_q <= emit_pre ? run_count_q : run_count_n;
		end
	end

	assign out_valid = out_valid_q;
	assign start_offset = start_offset_q;
	assign run_length = run_length_q;

endmodule

FILE: hw/rtl/printable_string_finder_top.sv
// Top level of the printable string finder: input register, configuration and run scanner.
//
// The block scans a file one byte word per cycle unless stalled and reports each run
// of string characters that reaches min_length as its start offset and its length.
// Input channel: in_valid / in_stall carry data_byte and end_of_file; a word is taken
// at a rising edge with in_valid high and in_stall low. end_of_file marks the last
// byte of a file; the open run is closed and the offset restarts at zero.
// Output channel: out_valid / out_stall carry start_offset and run_length; at most
// one result word follows each input word.
// A result word passes the input register and then the result register to the output.
// Throughput is one byte per cycle while the receiver does not stall.
// When the receiver stalls, the result register holds its word; one more input word
// is still taken into the input register if it is empty, after which in_stall rises
// until the output is drained.
// Configuration (cfg_write, cfg_index, cfg_data) is written while the block is idle.
// Reset clears the run state and the offset, sets min_length to 4 and both modes off.
module printable_string_finder_top #(
	parameter int OFFSET_BITS = psf_pkg::PSF_OFFSET_BITS,
	parameter int COUNT_BITS = psf_pkg::PSF_COUNT_BITS
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_write,
	input  logic [psf_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [psf_pkg::CFG_DATA_BITS-1:0]  cfg_data,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [7:0]                         data_byte,
	input  logic                               end_of_file,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [OFFSET_BITS-1:0]             start_offset,
	output logic [COUNT_BITS-1:0]              run_length
);
	import psf_pkg::*;

	cfg_t       cfg;
	logic       valid_s1;
	logic [7:0] data_byte_s1;
	logic       end_of_file_s1;
	logic       fire;

	psf_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// The input register stays full only while its word cannot move on.
	assign in_stall = valid_s1 && !fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			data_byte_s1 <= data_byte;
			end_of_file_s1 <= end_of_file;
		end
	end

	psf_scan #(
		.OFFSET_BITS (OFFSET_BITS),
		.COUNT_BITS  (COUNT_BITS)
	) u_scan (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg            (cfg),
		.valid_s1       (valid_s1),
		.data_byte_s1   (data_byte_s1),
		.end_of_file_s1 (end_of_file_s1),
		.fire           (fire),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.start_offset   (start_offset),
		.run_length     (run_length)
	);

endmodule

FILE: hw/rtl/psf_checker.sv
// Port-level assertions for the printable string finder, bound to its top level.
module psf_checker #(
	parameter int OFFSET_BITS = psf_pkg::PSF_OFFSET_BITS,
	parameter int COUNT_BITS = psf_pkg::PSF_COUNT_BITS
) (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   in_stall,
	input logic                   out_valid,
	input logic                   out_stall,
	input logic [OFFSET_BITS-1:0] start_offset,
	input logic [COUNT_BITS-1:0]  run_length
);

	// The input side only backs up behind a stalled result word.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall))
		else $error("input stalled without a stalled result word");

	// A reported run always holds at least one character.
	a_length_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (run_length != '0))
		else $error("result word with zero run length");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> out_valid)
		else $error("result word dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> ($stable(start_offset) && $stable(run_length)))
		else $error("result word changed while stalled");

endmodule

bind printable_string_finder_top psf_checker #(
	.OFFSET_BITS (OFFSET_BITS),
	.COUNT_BITS  (COUNT_BITS)
) u_psf_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_stall     (in_stall),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.start_offset (start_offset),
	.run_length   (run_length)
);

FILE: verif/printable_string_finder_top_tb.sv
// Self-checking testbench for the printable string finder: directed and random byte streams.
module printable_string_finder_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import psf_pkg::*;

	localparam int OFS = PSF_OFFSET_BITS;
	localparam int CNT = PSF_COUNT_BITS;
	localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE = 2'd3;
	localparam int SETTLE_CYCLES = 8;

	typedef struct packed {
		logic [OFS-1:0] start;
		logic [CNT-1:0] length;
	} run_report_t;

	// Tracks the run state of the byte stream and holds the reports still due from the block.
	class run_scoreboard;
		logic [MIN_LENGTH_BITS-1:0] min_len = DEF_MIN_LENGTH;
		logic escape = 1'b0;
		logic wide = 1'b0;
		logic [CNT-1:0] chars = '0;
		logic zero_due = 1'b0;
		logic [OFS-1:0] pos = '0;
		logic [OFS-1:0] run_first = '0;
		run_report_t reports_due[$];
		int errors = 0;
		int reports_seen = 0;

		function void configure(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
			case (idx)
				REG_MIN_LENGTH: min_len = data;
				REG_ESCAPE_MODE: escape = data[0];
				REG_WIDE_MODE: wide = data[0];
				default: ;
			endcase
		endfunction

		function logic is_char(logic [7:0] b);
			return (b >= CHR_SPACE && b <= CHR_TILDE) || (escape && b >= CHR_BEL && b <= CHR_CR);
		endfunction

		function logic long_enough();
			logic [CNT-1:0] need;
			need = (min_len == 0) ? CNT'(1) : CNT'(min_len);
			return !zero_due && chars != 0 && chars >= need;
		endfunction

		function void push_report();
			run_report_t r;
			r.start = run_first;
			r.length = chars;
			reports_due.push_back(r);
		endfunction

		function void note_byte(logic [7:0] b, logic eof);
			logic reported;
			reported = 1'b0;
			if (!is_char(b)) begin
				if (long_enough()) begin
					push_report();
					reported = 1'b1;
				end
				// A zero byte that was due only clears the flag and keeps the count.
				if (b != CHR_NUL || !zero_due)
					chars = '0;
				else
					zero_due = 1'b0;
			end else if (zero_due) begin
				chars = '0;
			end else begin
				if (wide)
					zero_due = 1'b1;
				if (chars == 0)
					run_first = pos;
				if (chars != '1)
					chars = chars + 1'b1;
			end
			if (eof) begin
				if (!reported && long_enough())
					push_report();
				chars = '0;
				zero_due = 1'b0;
				pos = '0;
			end else begin
				pos = pos + 1'b1;
			end
		endfunction

		function void check_report(logic [OFS-1:0] start, logic [CNT-1:0] length);
			run_report_t want;
			if (reports_due.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("Unexpected word: start %0h length %0d", start, length);
				return;
			end
			want = reports_due.pop_front();
			reports_seen++;
			if (want.start != start || want.length != length) begin
				errors++;
				if (errors <= 10)
					$display("Mismatch: expected start %0h length %0d, got start %0h length %0d",
						want.start, want.length, start, length);
			end
		endfunction

		function int pending();
			return reports_due.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_write = 1'b0;
	logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
	logic [CFG_DATA_BITS-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [7:0] data_byte = '0;
	logic end_of_file = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [OFS-1:0] start_offset;
	logic [CNT-1:0] run_length;

	run_scoreboard sb = new();
	int idle_pct = 0;
	int stall_pct = 0;
	int bytes_sent = 0;
	int setups = 0;

	printable_string_finder_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.data_byte(data_byte),
		.end_of_file(end_of_file),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.start_offset(start_offset),
		.run_length(run_length)
	);

	always #4 clk = ~clk;

	always @(posedge clk) begin
		out_stall <= ($urandom_range(0, 99) < stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_report(start_offset, run_length);
	end

	task automatic put_byte(logic [7:0] b, logic eof);
		while ($urandom_range(0, 99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		data_byte <= b;
		end_of_file <= eof;
		do
			@(posedge clk);
		while (in_stall);
		sb.note_byte(b, eof);
		bytes_sent++;
	endtask

	// Stops sending and waits until every report has come out and the pipeline is empty.
	task automatic drain();
		in_valid <= 1'b0;
		while (sb.pending() > 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		sb.configure(idx, data);
		cfg_write <= 1'b0;
		@(posedge clk);
	endtask

	task automatic apply_setup(logic [MIN_LENGTH_BITS-1:0] min_len, logic esc, logic wide);
		logic [CFG_DATA_BITS-2:0] junk_a;
		logic [CFG_DATA_BITS-2:0] junk_b;
		junk_a = (CFG_DATA_BITS-1)'($urandom);
		junk_b = (CFG_DATA_BITS-1)'($urandom);
		drain();
		write_reg(REG_MIN_LENGTH, min_len);
		write_reg(REG_ESCAPE_MODE, {junk_a, esc});
		write_reg(REG_WIDE_MODE, {junk_b, wide});
		write_reg(REG_SPARE, CFG_DATA_BITS'($urandom));
		setups++;
	endtask

	function automatic logic [7:0] pick_char();
		if (sb.escape && $urandom_range(0, 99) < 15)
			return 8'($urandom_range(CHR_BEL, CHR_CR));
		return 8'($urandom_range(CHR_SPACE, CHR_TILDE));
	endfunction

	function automatic logic [7:0] pick_stop();
		case ($urandom_range(0, 4))
			0: return CHR_NUL;
			1: return 8'($urandom_range(8'h01, 8'h06));
			2: return 8'($urandom_range(8'h0E, 8'h1F));
			3: return 8'($urandom_range(8'h7F, 8'hFF));
			default: return sb.escape ? 8'($urandom_range(8'h7F, 8'hFF))
				: 8'($urandom_range(CHR_BEL, CHR_CR));
		endcase
	endfunction

	task automatic put_random(logic [7:0] b);
		put_byte(b, $urandom_range(0, 99) < 3);
	endtask

	// Mostly well-formed runs, with the zero bytes of wide mode, plus some raw noise.
	task automatic send_random(int count);
		int target;
		int run_len;
		int room;
		target = bytes_sent + count;
		while (bytes_sent < target) begin
			if ($urandom_range(0, 99) < 70) begin
				run_len = ($urandom_range(0, 19) == 0) ? $urandom_range(60, 300)
					: $urandom_range(1, 10);
				// Keep the run inside the byte budget of this call.
				room = target - bytes_sent;
				if (sb.wide)
					room = (room + 1) / 2;
				if (run_len > room)
					run_len = room;
				for (int i = 0; i < run_len; i++) begin
					put_random(pick_char());
					if (sb.wide)
						put_random(($urandom_range(0, 99) < 95) ? CHR_NUL : 8'($urandom));
				end
				put_random(pick_stop());
			end else begin
				put_random(8'($urandom));
			end
		end
	endtask

	initial begin
		logic [MIN_LENGTH_BITS-1:0] phase_min[8] = '{16'd1, 16'd0, 16'd65535, 16'd4,
			16'd200, 16'd2, 16'd7, 16'd3};
		logic phase_esc[8] = '{1'b0, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1};
		logic phase_wide[8] = '{1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1};

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: printable range edges, short runs, and runs closed by end of file.
		put_byte(CHR_SPACE, 1'b0);
		put_byte("b", 1'b0);
		put_byte("c", 1'b0);
		put_byte(CHR_TILDE, 1'b0);
		put_byte(CHR_NUL, 1'b0);
		put_byte(8'h1F, 1'b0);
		put_byte("x", 1'b0);
		put_byte("y", 1'b0);
		put_byte(8'h7F, 1'b0);
		put_byte("p", 1'b0);
		put_byte("q", 1'b0);
		put_byte("r", 1'b0);
		put_byte("s", 1'b0);
		put_byte(8'hFF, 1'b1);
		put_byte("k", 1'b0);
		put_byte("l", 1'b0);
		put_byte("m", 1'b0);
		put_byte("n", 1'b1);

		// Escape and wide mode: control characters, a dropped run and a pending zero byte.
		apply_setup(16'd1, 1'b1, 1'b1);
		put_byte(CHR_BEL, 1'b0);
		put_byte(CHR_NUL, 1'b0);
		put_byte(CHR_CR, 1'b0);
		put_byte(CHR_NUL, 1'b0);
		put_byte(CHR_NUL, 1'b0);
		put_byte("a", 1'b0);
		put_byte("b", 1'b0);
		put_byte(8'h0A, 1'b0);
		put_byte(CHR_NUL, 1'b0);
		put_byte("z", 1'b1);

		for (int p = 0; p < 8; p++) begin
			apply_setup(phase_min[p], phase_esc[p], phase_wide[p]);
			case (p % 4)
				0: begin idle_pct = 0; stall_pct = 0; end
				1: begin idle_pct = 73; stall_pct = 0; end
				2: begin idle_pct = 0; stall_pct = 73; end
				default: begin idle_pct = 11; stall_pct = 11; end
			endcase
			send_random(80);
			// Let the block run completely dry in the middle of a phase.
			drain();
			send_random(80);
		end

		drain();
		$display("Sent %0d bytes under %0d register settings; %0d run reports checked.",
			bytes_sent, setups, sb.reports_seen);
		$display("Settings covered min_length 0, 1 and 65535, both modes, and every idle mix.");
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("%0d errors, %0d reports missing", sb.errors, sb.pending());
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

	initial begin
		#4000000;
		$display("Timeout with %0d reports still missing", sb.pending());
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
